// File: hw/rtl/scp_pkg.sv
// ============================================================================
// scp_pkg
// Widths, pipeline latencies and word types shared by the segment
// closest-point datapath.
// ============================================================================
package scp_pkg;

   localparam int CW      = 32;
   localparam int DLW     = 33;
   localparam int PRW     = 66;
   localparam int MW      = 68;
   localparam int HW      = 34;
   localparam int PW      = 136;
   localparam int DW      = 136;
   localparam int FW      = 32;
   localparam int QW      = 33;
   localparam int MUL_LAT = 4;
   localparam int DIV_LAT = 34;

   localparam logic [QW-1:0] Q_ONE = {1'b1, {FW{1'b0}}};

   typedef struct packed {
      logic signed [CW-1:0] a_start_x;
      logic signed [CW-1:0] a_start_y;
      logic signed [CW-1:0] a_start_z;
      logic signed [CW-1:0] a_end_x;
      logic signed [CW-1:0] a_end_y;
      logic signed [CW-1:0] a_end_z;
      logic signed [CW-1:0] b_start_x;
      logic signed [CW-1:0] b_start_y;
      logic signed [CW-1:0] b_start_z;
      logic signed [CW-1:0] b_end_x;
      logic signed [CW-1:0] b_end_y;
      logic signed [CW-1:0] b_end_z;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] near_a_x;
      logic signed [CW-1:0] near_a_y;
      logic signed [CW-1:0] near_a_z;
      logic signed [CW-1:0] near_b_x;
      logic signed [CW-1:0] near_b_y;
      logic signed [CW-1:0] near_b_z;
   } rsp_type;

endpackage

// File: hw/rtl/scp_mul.sv
// ============================================================================
// scp_mul
// Four-stage signed multiplier built from four 34 x 34 partial products on
// the operand magnitudes, with the sign applied in the last stage.
// ============================================================================
module scp_mul (
   input  logic                          clock,
   input  logic signed [scp_pkg::MW-1:0] x,
   input  logic signed [scp_pkg::MW-1:0] y,
   output logic signed [scp_pkg::PW-1:0] p
);
   import scp_pkg::*;

   logic [MW-1:0]        xa_ff, ya_ff, xa_in, ya_in;
   logic                 neg1_ff, neg2_ff, neg3_ff;
   logic [2*HW-1:0]      pp_ff [4];
   logic [2*HW-1:0]      pp_in [4];
   logic [PW-1:0]        sum_ff, sum_in;
   logic signed [PW-1:0] p_ff;

   always_comb begin
      xa_in    = x[MW-1] ? -x : x;
      ya_in    = y[MW-1] ? -y : y;
      pp_in[0] = (2*HW)'(xa_ff[HW-1:0]) * (2*HW)'(ya_ff[HW-1:0]);
      pp_in[1] = (2*HW)'(xa_ff[HW-1:0]) * (2*HW)'(ya_ff[MW-1:HW]);
      pp_in[2] = (2*HW)'(xa_ff[MW-1:HW]) * (2*HW)'(ya_ff[HW-1:0]);
      pp_in[3] = (2*HW)'(xa_ff[MW-1:HW]) * (2*HW)'(ya_ff[MW-1:HW]);
      sum_in   = PW'(pp_ff[0]) + (PW'(pp_ff[1]) << HW) + (PW'(pp_ff[2]) << HW)
               + (PW'(pp_ff[3]) << (2*HW));
   end

   always_ff @(posedge clock) begin
      xa_ff   <= xa_in;
      ya_ff   <= ya_in;
      neg1_ff <= x[MW-1] ^ y[MW-1];
      for (int k = 0; k < 4; k++) begin
         pp_ff[k] <= pp_in[k];
      end
      neg2_ff <= neg1_ff;
      sum_ff  <= sum_in;
      neg3_ff <= neg2_ff;
      p_ff    <= neg3_ff ? -$signed(sum_ff) : $signed(sum_ff);
   end

   assign p = p_ff;

endmodule

// File: hw/rtl/scp_div.sv
// ============================================================================
// scp_div
// Pipelined clamped fraction unit: gives num/den clamped to [0,1] as an
// unsigned Q1.32 value, one quotient bit per stage, rounded half up.
// ============================================================================
module scp_div (
   input  logic                          clock,
   input  logic signed [scp_pkg::DW-1:0] num,
   input  logic signed [scp_pkg::DW-1:0] den,
   output logic        [scp_pkg::QW-1:0] quo
);
   import scp_pkg::*;

   logic [DW-1:0] rem_ff  [FW+1];
   logic [DW-1:0] den_ff  [FW+1];
   logic [FW-1:0] q_ff    [FW+1];
   logic          zero_ff [FW+1];
   logic          one_ff  [FW+1];
   logic [DW-1:0] sh      [FW];
   logic [DW-1:0] nrem    [FW];
   logic          ge      [FW];
   logic [DW-1:0] rsh;
   logic          rup;
   logic [QW-1:0] quo_ff;

   always_comb begin
      for (int k = 0; k < FW; k++) begin
         sh[k]   = {rem_ff[k][DW-2:0], 1'b0};
         ge[k]   = sh[k] >= den_ff[k];
         nrem[k] = ge[k] ? sh[k] - den_ff[k] : sh[k];
      end
      rsh = {rem_ff[FW][DW-2:0], 1'b0};
      rup = rsh >= den_ff[FW];
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= num;
      den_ff[0]  <= den;
      q_ff[0]    <= '0;
      zero_ff[0] <= den[DW-1] || (den == '0) || num[DW-1] || (num == '0);
      one_ff[0]  <= num >= den;
      for (int k = 0; k < FW; k++) begin
         rem_ff[k+1]  <= nrem[k];
         den_ff[k+1]  <= den_ff[k];
         q_ff[k+1]    <= {q_ff[k][FW-2:0], ge[k]};
         zero_ff[k+1] <= zero_ff[k];
         one_ff[k+1]  <= one_ff[k];
      end
      if (zero_ff[FW]) begin
         quo_ff <= '0;
      end else if (one_ff[FW]) begin
         quo_ff <= Q_ONE;
      end else begin
         quo_ff <= QW'(q_ff[FW]) + QW'(rup);
      end
   end

   assign quo = quo_ff;

endmodule

// File: hw/rtl/segment_closest_points.sv
// ============================================================================
// segment_closest_points
// Closest points between two 3D segments in signed Q16.16, fully pipelined.
// ============================================================================
// Each accepted word produces one result strobe.
// Throughput is one word per cycle; busy is never raised.
// The latency is set by two chained 34-stage fraction units and two
// four-stage wide multipliers.
// Synchronous reset clears only the valid bits; no result follows reset.
module segment_closest_points (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  scp_pkg::req_type req_word,
   output logic             rsp_strobe,
   output scp_pkg::rsp_type rsp_word
);
   import scp_pkg::*;

   localparam int LAT = 3 + MUL_LAT + 1 + DIV_LAT + MUL_LAT + 1 + DIV_LAT + 3;

   typedef struct packed {
      logic [2:0][CW-1:0]  p1;
      logic [2:0][CW-1:0]  p2;
      logic [2:0][DLW-1:0] d1;
      logic [2:0][DLW-1:0] d2;
   } geo_type;

   typedef struct packed {
      geo_type              geo;
      logic signed [MW-1:0] a;
      logic signed [MW-1:0] b;
      logic signed [MW-1:0] c;
      logic signed [MW-1:0] e;
      logic signed [MW-1:0] f;
   } dot_type;

   typedef struct packed {
      geo_type              geo;
      logic signed [MW-1:0] a;
      logic signed [MW-1:0] b;
      logic signed [MW-1:0] e;
      logic signed [MW-1:0] f;
      logic                 az;
      logic                 ez;
   } frac_type;

   typedef struct packed {
      geo_type              geo;
      logic signed [MW-1:0] e;
      logic signed [MW-1:0] f;
      logic                 az;
      logic                 ez;
      logic [QW-1:0]        q1;
      logic [QW-1:0]        q2;
      logic [QW-1:0]        q3;
      logic [QW-1:0]        q4;
   } tpar_type;

   typedef struct packed {
      geo_type       geo;
      logic          az;
      logic          ez;
      logic          tneg;
      logic          tgt;
      logic [QW-1:0] q1;
      logic [QW-1:0] q2;
      logic [QW-1:0] q3;
      logic [QW-1:0] q4;
   } sel_type;

   logic [LAT-1:0] vld_ff;

   logic signed [CW-1:0] sa [3];
   logic signed [CW-1:0] ea [3];
   logic signed [CW-1:0] sb [3];
   logic signed [CW-1:0] eb [3];

   geo_type               geo1_in, geo1_ff, geo2_ff;
   logic [2:0][DLW-1:0]   r1_in, r1_ff;
   logic signed [PRW-1:0] aa2_ff [3];
   logic signed [PRW-1:0] ee2_ff [3];
   logic signed [PRW-1:0] ff2_ff [3];
   logic signed [PRW-1:0] cc2_ff [3];
   logic signed [PRW-1:0] bb2_ff [3];
   dot_type               dot3_ff;
   dot_type               dot_dl_ff [MUL_LAT];
   dot_type               dot_last;

   logic signed [PW-1:0] ae_p, bb_p, bf_p, ce_p;
   logic signed [DW-1:0] den8_ff, num8_ff, nc8_ff, bmc8_ff;
   frac_type             frac8_ff;
   frac_type             frac_dl_ff [DIV_LAT];
   frac_type             frac_last;
   logic [QW-1:0]        q1, q2, q3, q4, q5;

   tpar_type             tpar_in;
   tpar_type             tpar_dl_ff [MUL_LAT];
   tpar_type             tpar_last;
   logic signed [PW-1:0] bs_p;
   logic signed [DW-1:0] tnum_ff, eone_ff;
   tpar_type             tpar47_ff;
   sel_type              sel_in;
   sel_type              sel_dl_ff [DIV_LAT];
   sel_type              sel_last;

   logic [QW-1:0]      s_in, t_in, s_ff, t_ff;
   geo_type            geo82_ff;
   logic [2*QW-1:0]    prod_in [6];
   logic [2*QW-1:0]    prod_ff [6];
   logic               neg_in [6];
   logic               neg_ff [6];
   logic [CW-1:0]      base_in [6];
   logic [CW-1:0]      base_ff [6];
   logic [DLW-1:0]     dsel [6];
   logic [DLW-1:0]     mag [6];
   logic [2*QW-1:0]    rnd [6];
   logic [CW+1:0]      off [6];
   logic signed [CW+2:0] offs [6];
   logic signed [CW+3:0] sum [6];
   logic [CW-1:0]      out_in [6];
   logic [CW-1:0]      out_ff [6];

   assign busy = 1'b0;

   // Stage 1: edge vectors of both segments and the start-to-start vector.
   always_comb begin
      sa[0] = req_word.a_start_x;  sa[1] = req_word.a_start_y;  sa[2] = req_word.a_start_z;
      ea[0] = req_word.a_end_x;    ea[1] = req_word.a_end_y;    ea[2] = req_word.a_end_z;
      sb[0] = req_word.b_start_x;  sb[1] = req_word.b_start_y;  sb[2] = req_word.b_start_z;
      eb[0] = req_word.b_end_x;    eb[1] = req_word.b_end_y;    eb[2] = req_word.b_end_z;
      for (int i = 0; i < 3; i++) begin
         geo1_in.p1[i] = sa[i];
         geo1_in.p2[i] = sb[i];
         geo1_in.d1[i] = DLW'(ea[i]) - DLW'(sa[i]);
         geo1_in.d2[i] = DLW'(eb[i]) - DLW'(sb[i]);
         r1_in[i]      = DLW'(sa[i]) - DLW'(sb[i]);
      end
   end

   always_ff @(posedge clock) begin
      geo1_ff <= geo1_in;
      r1_ff   <= r1_in;
      geo2_ff <= geo1_ff;
      for (int i = 0; i < 3; i++) begin
         aa2_ff[i] <= PRW'($signed(geo1_ff.d1[i])) * PRW'($signed(geo1_ff.d1[i]));
         ee2_ff[i] <= PRW'($signed(geo1_ff.d2[i])) * PRW'($signed(geo1_ff.d2[i]));
         ff2_ff[i] <= PRW'($signed(geo1_ff.d2[i])) * PRW'($signed(r1_ff[i]));
         cc2_ff[i] <= PRW'($signed(geo1_ff.d1[i])) * PRW'($signed(r1_ff[i]));
         bb2_ff[i] <= PRW'($signed(geo1_ff.d1[i])) * PRW'($signed(geo1_ff.d2[i]));
      end
      dot3_ff.geo <= geo2_ff;
      dot3_ff.a <= MW'(aa2_ff[0]) + MW'(aa2_ff[1]) + MW'(aa2_ff[2]);
      dot3_ff.e <= MW'(ee2_ff[0]) + MW'(ee2_ff[1]) + MW'(ee2_ff[2]);
      dot3_ff.f <= MW'(ff2_ff[0]) + MW'(ff2_ff[1]) + MW'(ff2_ff[2]);
      dot3_ff.c <= MW'(cc2_ff[0]) + MW'(cc2_ff[1]) + MW'(cc2_ff[2]);
      dot3_ff.b <= MW'(bb2_ff[0]) + MW'(bb2_ff[1]) + MW'(bb2_ff[2]);
   end

   scp_mul u_mul_ae (.clock(clock), .x(dot3_ff.a), .y(dot3_ff.e), .p(ae_p));
   scp_mul u_mul_bb (.clock(clock), .x(dot3_ff.b), .y(dot3_ff.b), .p(bb_p));
   scp_mul u_mul_bf (.clock(clock), .x(dot3_ff.b), .y(dot3_ff.f), .p(bf_p));
   scp_mul u_mul_ce (.clock(clock), .x(dot3_ff.c), .y(dot3_ff.e), .p(ce_p));

   assign dot_last = dot_dl_ff[MUL_LAT-1];

   always_ff @(posedge clock) begin
      dot_dl_ff[0] <= dot3_ff;
      for (int k = 1; k < MUL_LAT; k++) begin
         dot_dl_ff[k] <= dot_dl_ff[k-1];
      end
      den8_ff      <= ae_p - bb_p;
      num8_ff      <= bf_p - ce_p;
      nc8_ff       <= -DW'(dot_last.c);
      bmc8_ff      <= DW'(dot_last.b) - DW'(dot_last.c);
      frac8_ff.geo <= dot_last.geo;
      frac8_ff.a   <= dot_last.a;
      frac8_ff.b   <= dot_last.b;
      frac8_ff.e   <= dot_last.e;
      frac8_ff.f   <= dot_last.f;
      frac8_ff.az  <= dot_last.a == '0;
      frac8_ff.ez  <= dot_last.e == '0;
   end

   scp_div u_div_gen (.clock(clock), .num(num8_ff), .den(den8_ff), .quo(q1));
   scp_div u_div_nc (.clock(clock), .num(nc8_ff), .den(DW'(frac8_ff.a)), .quo(q2));
   scp_div u_div_bc (.clock(clock), .num(bmc8_ff), .den(DW'(frac8_ff.a)), .quo(q3));
   scp_div u_div_fe (.clock(clock), .num(DW'(frac8_ff.f)), .den(DW'(frac8_ff.e)),
                     .quo(q4));

   assign frac_last = frac_dl_ff[DIV_LAT-1];

   always_comb begin
      tpar_in.geo = frac_last.geo;
      tpar_in.e   = frac_last.e;
      tpar_in.f   = frac_last.f;
      tpar_in.az  = frac_last.az;
      tpar_in.ez  = frac_last.ez;
      tpar_in.q1  = q1;
      tpar_in.q2  = q2;
      tpar_in.q3  = q3;
      tpar_in.q4  = q4;
   end

   scp_mul u_mul_bs (.clock(clock), .x(frac_last.b), .y($signed(MW'(q1))), .p(bs_p));

   assign tpar_last = tpar_dl_ff[MUL_LAT-1];

   always_ff @(posedge clock) begin
      frac_dl_ff[0] <= frac8_ff;
      for (int k = 1; k < DIV_LAT; k++) begin
         frac_dl_ff[k] <= frac_dl_ff[k-1];
      end
      tpar_dl_ff[0] <= tpar_in;
      for (int k = 1; k < MUL_LAT; k++) begin
         tpar_dl_ff[k] <= tpar_dl_ff[k-1];
      end
      tnum_ff   <= bs_p + (DW'(tpar_last.f) <<< FW);
      eone_ff   <= DW'(tpar_last.e) <<< FW;
      tpar47_ff <= tpar_last;
   end

   scp_div u_div_t (.clock(clock), .num(tnum_ff), .den(eone_ff), .quo(q5));

   always_comb begin
      sel_in.geo  = tpar47_ff.geo;
      sel_in.az   = tpar47_ff.az;
      sel_in.ez   = tpar47_ff.ez;
      sel_in.tneg = tnum_ff[DW-1];
      sel_in.tgt  = tnum_ff > eone_ff;
      sel_in.q1   = tpar47_ff.q1;
      sel_in.q2   = tpar47_ff.q2;
      sel_in.q3   = tpar47_ff.q3;
      sel_in.q4   = tpar47_ff.q4;
   end

   assign sel_last = sel_dl_ff[DIV_LAT-1];

   // Case selection for the two segment parameters.
   always_comb begin
      priority if (sel_last.az && sel_last.ez) begin
         s_in = '0;
         t_in = '0;
      end else if (sel_last.az) begin
         s_in = '0;
         t_in = sel_last.q4;
      end else if (sel_last.ez) begin
         s_in = sel_last.q2;
         t_in = '0;
      end else if (sel_last.tneg) begin
         s_in = sel_last.q2;
         t_in = '0;
      end else if (sel_last.tgt) begin
         s_in = sel_last.q3;
         t_in = Q_ONE;
      end else begin
         s_in = sel_last.q1;
         t_in = q5;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dsel[i]      = geo82_ff.d1[i];
         dsel[3+i]    = geo82_ff.d2[i];
         base_in[i]   = geo82_ff.p1[i];
         base_in[3+i] = geo82_ff.p2[i];
      end
      for (int j = 0; j < 6; j++) begin
         mag[j]     = dsel[j][DLW-1] ? -dsel[j] : dsel[j];
         neg_in[j]  = dsel[j][DLW-1];
         prod_in[j] = (2*QW)'(mag[j]) * (2*QW)'((j < 3) ? s_ff : t_ff);
         rnd[j]     = prod_ff[j] + ((2*QW)'(1) << (FW - 1));
         off[j]     = rnd[j][2*QW-1:FW];
         offs[j]    = neg_ff[j] ? -$signed({1'b0, off[j]}) : $signed({1'b0, off[j]});
         sum[j]     = (CW+4)'($signed(base_ff[j])) + (CW+4)'(offs[j]);
         if (sum[j][CW+3:CW-1] == '0 || sum[j][CW+3:CW-1] == '1) begin
            out_in[j] = sum[j][CW-1:0];
         end else begin
            out_in[j] = sum[j][CW+3] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      sel_dl_ff[0] <= sel_in;
      for (int k = 1; k < DIV_LAT; k++) begin
         sel_dl_ff[k] <= sel_dl_ff[k-1];
      end
      s_ff     <= s_in;
      t_ff     <= t_in;
      geo82_ff <= sel_last.geo;
      for (int j = 0; j < 6; j++) begin
         prod_ff[j] <= prod_in[j];
         neg_ff[j]  <= neg_in[j];
         base_ff[j] <= base_in[j];
         out_ff[j]  <= out_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start & ~busy};
      end
   end

   assign rsp_strobe        = vld_ff[LAT-1];
   assign rsp_word.near_a_x = out_ff[0];
   assign rsp_word.near_a_y = out_ff[1];
   assign rsp_word.near_a_z = out_ff[2];
   assign rsp_word.near_b_x = out_ff[3];
   assign rsp_word.near_b_y = out_ff[4];
   assign rsp_word.near_b_z = out_ff[5];

   // Every accepted word comes out exactly once, after the fixed latency.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_strobe)
      else $error("accepted word did not produce a result in time");

   // Reset flushes the pipeline.
   assert property (@(posedge clock) $past(reset) |-> !rsp_strobe)
      else $error("result strobe after reset");

   // Two point segments return their start points unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.a_start_x == req_word.a_end_x
       && req_word.a_start_y == req_word.a_end_y
       && req_word.a_start_z == req_word.a_end_z
       && req_word.b_start_x == req_word.b_end_x
       && req_word.b_start_y == req_word.b_end_y
       && req_word.b_start_z == req_word.b_end_z)
      |-> ##LAT (rsp_word.near_a_x == $past(req_word.a_start_x, LAT)
                 && rsp_word.near_b_z == $past(req_word.b_start_z, LAT)))
      else $error("degenerate segments did not return start points");

   // The closest point on the first segment lies between its endpoints.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.a_start_x <= req_word.a_end_x)
      |-> ##LAT (rsp_word.near_a_x >= $past(req_word.a_start_x, LAT)
                 && rsp_word.near_a_x <= $past(req_word.a_end_x, LAT)))
      else $error("closest point left its segment");

endmodule
